// ----- hw/rtl/sti_pkg.sv -----
// Shared types and constants for the sorted table insert/search block.
// Used by sti_engine and sorted_table_insert_search; no dependencies.
package sti_pkg;

    localparam int KEY_W      = 32;
    localparam int FUNC_W     = 2;
    localparam int POS_W      = 10;
    localparam int PROBE_W    = 11;
    localparam int CAP_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BSEARCH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LSEARCH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDERED_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 2'd1;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic signed [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic               status;
        logic               found;
        logic [POS_W-1:0]   position;
        logic [PROBE_W-1:0] probes;
    } rsp_t;

    typedef struct packed {
        logic             ordered_mode;
        logic [CAP_W-1:0] capacity;
    } cfg_t;

endpackage

// ----- hw/rtl/sti_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/sti_engine.sv -----
// Sequencer for insert, binary search and linear search over the key RAM.
// Depends on sti_pkg and sti_ram.
module sti_engine
    import sti_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int AW   = $clog2(MAX_ENTRIES);
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_INS_CHK,
        S_INS_PUT,
        S_BIN_RD,
        S_BIN_CMP,
        S_LIN_CMP,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    req_t              req_reg, req_next;
    rsp_t              rsp_reg, rsp_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     slot_reg, slot_next;
    logic [CW-1:0]     lo_reg, lo_next;
    logic [CW-1:0]     hi_ex_reg, hi_ex_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     probe_reg, probe_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [KEY_W-1:0]  wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [KEY_W-1:0]  rd_data;

    logic              full;
    logic [CW:0]       mid_sum;
    logic [AW-1:0]     mid;
    logic [CW-1:0]     idx_inc;

    sti_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign full = (CMPW'(count_reg) >= CMPW'(cfg.capacity)) ||
                  (count_reg >= CW'(MAX_ENTRIES));
    // floor((lo + hi) / 2) with hi = hi_ex - 1
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_ex_reg} - (CW+1)'(1);
    assign mid     = AW'(mid_sum >> 1);
    assign idx_inc = CW'(idx_reg) + CW'(1);

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_DONE);
    assign rsp       = rsp_reg;

    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        rsp_next   = rsp_reg;
        count_next = count_reg;
        slot_next  = slot_reg;
        lo_next    = lo_reg;
        hi_ex_next = hi_ex_reg;
        idx_next   = idx_reg;
        probe_next = probe_reg;
        wr_en      = 1'b0;
        wr_addr    = slot_reg;
        wr_data    = req_reg.key;
        rd_en      = 1'b0;
        rd_addr    = idx_reg;

        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    req_next   = req;
                    state_next = S_START;
                end
            end
            S_START: begin
                rsp_next   = '0;
                state_next = S_DONE;
                case (req_reg.func)
                    FUNC_INSERT: begin
                        if (full) begin
                            rsp_next.status = 1'b1;
                        end else begin
                            count_next = count_reg + CW'(1);
                            if (!cfg.ordered_mode || count_reg == '0) begin
                                wr_en   = 1'b1;
                                wr_addr = AW'(count_reg);
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(count_reg - CW'(1));
                                slot_next  = AW'(count_reg);
                                state_next = S_INS_CHK;
                            end
                        end
                    end
                    FUNC_BSEARCH: begin
                        lo_next    = '0;
                        hi_ex_next = count_reg;
                        probe_next = '0;
                        state_next = S_BIN_RD;
                    end
                    FUNC_LSEARCH: begin
                        if (count_reg != '0) begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            idx_next   = '0;
                            state_next = S_LIN_CMP;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_INS_CHK: begin
                // rd_data holds entry slot-1; shift it up if larger than the key
                if ($signed(rd_data) > req_reg.key) begin
                    wr_en   = 1'b1;
                    wr_addr = slot_reg;
                    wr_data = rd_data;
                    slot_next = slot_reg - AW'(1);
                    if (slot_reg == AW'(1)) begin
                        state_next = S_INS_PUT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = slot_reg - AW'(2);
                    end
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = slot_reg;
                    state_next = S_DONE;
                end
            end
            S_INS_PUT: begin
                wr_en      = 1'b1;
                wr_addr    = slot_reg;
                state_next = S_DONE;
            end
            S_BIN_RD: begin
                if (lo_reg < hi_ex_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = mid;
                    idx_next   = mid;
                    probe_next = probe_reg + CW'(1);
                    state_next = S_BIN_CMP;
                end else begin
                    rsp_next.probes = PROBE_W'(probe_reg);
                    state_next      = S_DONE;
                end
            end
            S_BIN_CMP: begin
                if ($signed(rd_data) == req_reg.key) begin
                    rsp_next.found    = 1'b1;
                    rsp_next.position = POS_W'(idx_reg);
                    rsp_next.probes   = PROBE_W'(probe_reg);
                    state_next        = S_DONE;
                end else if ($signed(rd_data) > req_reg.key) begin
                    hi_ex_next = CW'(idx_reg);
                    state_next = S_BIN_RD;
                end else begin
                    lo_next    = CW'(idx_reg) + CW'(1);
                    state_next = S_BIN_RD;
                end
            end
            S_LIN_CMP: begin
                // rd_data holds entry idx; fetch idx+1 while comparing
                if ($signed(rd_data) == req_reg.key) begin
                    rsp_next.found    = 1'b1;
                    rsp_next.position = POS_W'(idx_reg);
                    rsp_next.probes   = PROBE_W'(idx_inc);
                    state_next        = S_DONE;
                end else if (idx_inc < count_reg) begin
                    rd_en    = 1'b1;
                    rd_addr  = AW'(idx_inc);
                    idx_next = AW'(idx_inc);
                end else begin
                    rsp_next.probes = PROBE_W'(count_reg);
                    state_next      = S_DONE;
                end
            end
            S_DONE: begin
                if (rsp_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        req_reg   <= req_next;
        rsp_reg   <= rsp_next;
        slot_reg  <= slot_next;
        lo_reg    <= lo_next;
        hi_ex_reg <= hi_ex_next;
        idx_reg   <= idx_next;
        probe_reg <= probe_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count above table depth");

    a_write_only_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == S_START || state_reg == S_INS_CHK ||
                   state_reg == S_INS_PUT))
        else $error("key RAM written outside an insert");

    a_bin_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BIN_CMP) |-> (CW'(idx_reg) < hi_ex_reg && CW'(idx_reg) >= lo_reg))
        else $error("binary probe outside search window");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_START) |=> $stable(count_reg))
        else $error("entry count changed outside insert dispatch");
`endif

endmodule

// ----- hw/rtl/sorted_table_insert_search.sv -----
// Sorted key table with insert, binary search and linear search (top level).
// Depends on sti_pkg and sti_engine (which holds the key RAM in sti_ram).
//
// The block keeps up to MAX_ENTRIES signed 32-bit keys in a single-port-read,
// single-port-write RAM plus an entry count, and handles one request at a
// time. Each request yields exactly one response. An ordered insert into a
// non-empty table shifts up every stored entry larger than the key, with one
// RAM read and one write per shifted entry, overlapped; a linear search
// overlaps its RAM reads with the compares; a binary search waits on each
// RAM read before the next midpoint is known. The longest requests are those
// in which the RAM read port walks the whole table. A new request is taken as
// soon as the previous one has left the sequencer, even while its response
// still waits in the output register. Configuration writes (ordered_mode at
// index 0, capacity at index 1) are always accepted and should be issued
// only while no request is in flight. The key RAM needs no clearing after
// reset: only entries below the count are ever read.
module sorted_table_insert_search
    import sti_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  req_t                  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rsp_t                  m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic m_valid_reg, m_valid_next;
    rsp_t m_data_reg, m_data_next;

    logic eng_rsp_valid;
    logic eng_rsp_ready;
    rsp_t eng_rsp;

    // Configuration writes are never stalled.
    assign cfg_ready = 1'b1;

    // Decode register writes; unknown indexes are dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_ORDERED_MODE: cfg_next.ordered_mode = cfg_data[0];
                CFG_CAPACITY:     cfg_next.capacity     = CAP_W'(cfg_data);
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    sti_engine #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (s_data),
        .rsp_valid (eng_rsp_valid),
        .rsp_ready (eng_rsp_ready),
        .rsp       (eng_rsp)
    );

    // Load the output register when it is empty or being drained this cycle;
    // otherwise hold the finished response in the sequencer.
    assign eng_rsp_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (eng_rsp_ready) begin
            m_valid_next = eng_rsp_valid;
            if (eng_rsp_valid) begin
                m_data_next = eng_rsp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ordered_mode <= 1'b1;
            cfg_reg.capacity     <= CAP_W'(1024);
            m_valid_reg          <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_hold_unaccepted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("response dropped or changed while stalled");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (eng_rsp_valid && eng_rsp_ready) |=> m_valid)
        else $error("handed-off response not presented");

    a_search_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.found) |-> !m_data.status)
        else $error("found and error flagged together");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for sorted_table_insert_search: directed rows, then random traffic.
// Uses the shared types and codes of sti_pkg; expected responses come from a table model
// built into this file.
module tb;
    import sti_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_DEPTH      = 1024;
    localparam int SETTLE_CYCLES  = 8;
    // Worst request is a full-table walk.
    localparam int TAIL_CYCLES    = TBL_DEPTH + 16;
    // Several times the longest quiet stretch a healthy run can show:
    // a full walk plus the longest receiver stall and sender gap.
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int MAX_REPORTS    = 10;
    localparam int N_DIR          = 28;

    // Codes the package leaves unnamed.
    localparam logic [FUNC_W-1:0]    FUNC_UNUSED    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

    localparam rsp_t RSP_OK   = '0;
    localparam rsp_t RSP_FULL = '{status: 1'b1, found: 1'b0, position: '0, probes: '0};

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

    // One line of the directed part: a request (with an optional typed-in
    // response) or a register write.
    typedef struct packed {
        row_kind_e             kind;
        logic                  typed;
        req_t                  req;
        rsp_t                  rsp;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_val;
    } row_t;

    typedef enum logic [1:0] {RX_OPEN, RX_SPARSE, RX_COIN, RX_WINDOW} rx_mode_e;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    req_t                  s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    rsp_t                  m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    sorted_table_insert_search #(
        .MAX_ENTRIES(TBL_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Table model: our own copy of the key store, the count and the two
    // registers, at their reset values.
    // ------------------------------------------------------------------
    logic signed [KEY_W-1:0] tbl_keys [TBL_DEPTH];
    int unsigned             tbl_count   = 0;
    logic                    tbl_ordered = 1'b1;
    logic [CAP_W-1:0]        tbl_cap     = 11'd1024;

    rsp_t pending_rsps [$];
    int   mismatch_count = 0;

    // Apply one request to the model and return the response it must give.
    // Searches leave the model untouched.
    function automatic rsp_t table_apply(req_t r);
        rsp_t                    o;
        logic signed [KEY_W-1:0] k;
        int unsigned             eff;
        int unsigned             slot;
        int unsigned             n_probe;
        int                      lo;
        int                      hi;
        int                      mid;
        o = '0;
        k = r.key;
        n_probe = 0;
        case (r.func)
            FUNC_INSERT: begin
                // Capacity above the depth saturates; zero refuses everything.
                eff = (tbl_cap > TBL_DEPTH) ? TBL_DEPTH : tbl_cap;
                if (tbl_count >= eff) begin
                    o.status = 1'b1;
                end else begin
                    if (tbl_ordered) begin
                        // Shift strictly larger keys up, so equal keys keep arrival order.
                        slot = tbl_count;
                        while (slot > 0 && tbl_keys[slot-1] > k) begin
                            tbl_keys[slot] = tbl_keys[slot-1];
                            slot--;
                        end
                        tbl_keys[slot] = k;
                    end else begin
                        tbl_keys[tbl_count] = k;
                    end
                    tbl_count++;
                end
            end
            FUNC_BSEARCH: begin
                // Follows the usual probe sequence even on an unsorted table.
                lo = 0;
                hi = int'(tbl_count) - 1;
                while (lo <= hi) begin
                    mid = (lo + hi) / 2;
                    n_probe++;
                    if (tbl_keys[mid] == k) begin
                        o.found    = 1'b1;
                        o.position = mid[POS_W-1:0];
                        break;
                    end
                    if (tbl_keys[mid] > k) hi = mid - 1;
                    else lo = mid + 1;
                end
                o.probes = n_probe[PROBE_W-1:0];
            end
            FUNC_LSEARCH: begin
                n_probe = tbl_count;
                for (int unsigned i = 0; i < tbl_count; i++) begin
                    if (tbl_keys[i] == k) begin
                        o.found    = 1'b1;
                        o.position = i[POS_W-1:0];
                        n_probe    = i + 1;
                        break;
                    end
                end
                o.probes = n_probe[PROBE_W-1:0];
            end
            default: begin
                // Unused code: nothing changes, the response stays all zero.
            end
        endcase
        return o;
    endfunction

    function automatic void table_config(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_ORDERED_MODE: tbl_ordered = val[0];
            CFG_CAPACITY:     tbl_cap     = val;
            default: begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Directed rows.
    // ------------------------------------------------------------------
    function automatic row_t req_row(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k);
        row_t r;
        r = '0;
        r.kind     = ROW_REQ;
        r.req.func = f;
        r.req.key  = k;
        return r;
    endfunction

    function automatic row_t checked_row(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                                         rsp_t rsp);
        row_t r;
        r = req_row(f, k);
        r.typed = 1'b1;
        r.rsp   = rsp;
        return r;
    endfunction

    function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                     logic [CFG_DATA_W-1:0] val);
        row_t r;
        r = '0;
        r.kind    = ROW_CFG;
        r.cfg_idx = idx;
        r.cfg_val = val;
        return r;
    endfunction

    row_t directed_rows [N_DIR];

    // ------------------------------------------------------------------
    // Random request content.
    // ------------------------------------------------------------------
    // Mix stored keys (hits), extremes, a narrow band (duplicates) and
    // full-range noise.
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40 && tbl_count > 0) return tbl_keys[$urandom_range(0, tbl_count - 1)];
        if (roll < 50) begin
            case ($urandom_range(0, 4))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return '0;
                3: return '1;
                default: return 32'd1;
            endcase
        end
        if (roll < 70) return KEY_W'(int'($urandom_range(0, 100)) - 50);
        return $urandom;
    endfunction

    function automatic req_t pick_req(int unsigned insert_pct);
        req_t        r;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < insert_pct) r.func = FUNC_INSERT;
        else if ($urandom_range(0, 24) == 0) r.func = FUNC_UNUSED;
        else if ($urandom_range(0, 1) == 0) r.func = FUNC_BSEARCH;
        else r.func = FUNC_LSEARCH;
        r.key = pick_key();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------
    // Present one request and hold it until accepted; valid stays high on
    // return so a back-to-back request does not drop it. On acceptance,
    // queue either the typed-in response or the model's.
    task automatic send_req(input req_t r, input logic typed, input rsp_t rsp);
        rsp_t pred;
        cfg_valid <= 1'b0;      // drop a register write still being held
        s_valid   <= 1'b1;
        s_data    <= r;
        do @(posedge aclk); while (!s_ready);
        pred = table_apply(r);
        pending_rsps.push_back(typed ? rsp : pred);
    endtask

    // Hold a register write until accepted, then update the model.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        table_config(idx, val);
    endtask

    // Stop sending, wait for every outstanding response, then let the
    // block sit idle a little before any register is touched.
    task automatic settle();
        s_valid   <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_rsps.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_ordered(input logic mode);
        logic [CFG_DATA_W-1:0] val;
        val    = CFG_DATA_W'($urandom);   // upper bits are don't-care
        val[0] = mode;
        write_cfg(CFG_ORDERED_MODE, val);
    endtask

    // Random traffic in bursts of random length with random gaps; now and
    // then hold off until the block has drained completely.
    task automatic run_random(input int unsigned n_items, input int unsigned insert_pct);
        int unsigned left;
        int unsigned burst;
        int unsigned gap;
        logic        drain;
        left = n_items;
        while (left > 0) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(24, 64)
                                                : $urandom_range(1, 12);
            gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            drain = ($urandom_range(0, 29) == 0);
            if (drain && gap == 0) gap = 1;
            if (gap != 0) begin
                s_valid   <= 1'b0;
                cfg_valid <= 1'b0;
            end
            if (drain) begin
                while (pending_rsps.size() != 0) @(posedge aclk);
            end
            repeat (gap) @(posedge aclk);
            while (burst > 0 && left > 0) begin
                send_req(pick_req(insert_pct), 1'b0, RSP_OK);
                burst--;
                left--;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side: ready follows a randomly chosen stall mode
    // (always ready, one stall in five, coin toss, long window).
    // ------------------------------------------------------------------
    rx_mode_e    rx_mode  = RX_OPEN;
    int unsigned rx_cycle = 0;

    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 256 == 255) rx_mode <= rx_mode_e'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_SPARSE: m_ready <= (rx_cycle % 5) != 0;
            RX_COIN:   m_ready <= ($urandom_range(0, 1) != 0);
            default:   m_ready <= (rx_cycle % 16) >= 12;
        endcase
    end

    // ------------------------------------------------------------------
    // Response check: compare each accepted response with the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input rsp_t want, input rsp_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s: expected status=%0d found=%0d position=%0d probes=%0d",
                     $realtime, what, want.status, want.found, want.position, want.probes,
                     ", got status=%0d found=%0d position=%0d probes=%0d",
                     got.status, got.found, got.position, got.probes);
    endtask

    always @(posedge aclk) begin : rsp_check
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsps.size() == 0) begin
                report_mismatch("response with no request outstanding", RSP_OK, m_data);
            end else begin
                want = pending_rsps.pop_front();
                if (m_data.status !== want.status || m_data.found !== want.found ||
                    m_data.position !== want.position || m_data.probes !== want.probes)
                    report_mismatch("response mismatch", want, m_data);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when no channel has moved for too long.
    // ------------------------------------------------------------------
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin : stimulus
        req_t r;
        rsp_t probe_rsp;

        // Empty table first, then extremes and duplicates in ordered mode,
        // then capacity zero, a full table, and unordered append.
        directed_rows = '{
            checked_row(FUNC_BSEARCH, 32'd5,        RSP_OK),   // search of empty table
            checked_row(FUNC_LSEARCH, -5,           RSP_OK),
            checked_row(FUNC_UNUSED,  '1,           RSP_OK),
            checked_row(FUNC_INSERT,  KEY_MAX,      RSP_OK),
            checked_row(FUNC_INSERT,  KEY_MIN,      RSP_OK),
            checked_row(FUNC_INSERT,  '0,           RSP_OK),
            checked_row(FUNC_INSERT,  '1,           RSP_OK),
            checked_row(FUNC_INSERT,  '0,           RSP_OK),   // equal key lands after
            req_row    (FUNC_LSEARCH, KEY_MAX),
            req_row    (FUNC_BSEARCH, KEY_MIN),
            req_row    (FUNC_BSEARCH, '0),
            req_row    (FUNC_LSEARCH, '0),
            req_row    (FUNC_BSEARCH, 32'd12345),
            req_row    (FUNC_LSEARCH, 32'h5555_AAAA),
            checked_row(FUNC_UNUSED,  32'd42,       RSP_OK),
            cfg_row    (CFG_CAPACITY, 11'd0),
            checked_row(FUNC_INSERT,  32'd7,        RSP_FULL), // capacity zero refuses
            cfg_row    (CFG_CAPACITY, 11'd5),
            checked_row(FUNC_INSERT,  32'd7,        RSP_FULL), // table exactly full
            cfg_row    (CFG_CAPACITY, 11'd6),
            cfg_row    (CFG_ORDERED_MODE, 11'd0),
            checked_row(FUNC_INSERT,  32'd1,        RSP_OK),   // appended at the end
            checked_row(FUNC_INSERT,  32'd2,        RSP_FULL),
            req_row    (FUNC_LSEARCH, 32'd1),
            req_row    (FUNC_BSEARCH, 32'd1),                  // binary probe on unsorted data
            cfg_row    (CFG_UNUSED_IDX, 11'h7FF),
            cfg_row    (CFG_ORDERED_MODE, 11'd1),
            cfg_row    (CFG_CAPACITY, 11'h7FF)
        };

        // Reset once.
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                settle();
                write_cfg(directed_rows[i].cfg_idx, directed_rows[i].cfg_val);
            end else begin
                send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
            end
        end

        // Ordered table with a small capacity: grows until full.
        settle();
        write_ordered(1'b1);
        write_cfg(CFG_CAPACITY, CFG_DATA_W'($urandom_range(50, 70)));
        run_random(180, 45);

        // Unordered appends on top of the sorted part.
        settle();
        write_ordered(1'b0);
        write_cfg(CFG_CAPACITY, CFG_DATA_W'(tbl_count + 60));
        run_random(120, 40);

        // Capacity lowered below the count: inserts refused, entries stay searchable.
        settle();
        write_ordered(1'($urandom_range(0, 1)));
        write_cfg(CFG_CAPACITY, CFG_DATA_W'($urandom_range(0, tbl_count - 1)));
        run_random(60, 50);

        // Ordered again at the reset capacity.
        settle();
        write_ordered(1'b1);
        write_cfg(CFG_CAPACITY, 11'd1024);
        run_random(150, 45);

        // Capacity above the depth saturates to it: a run of appends, then
        // searches over every stored entry.
        settle();
        write_ordered(1'b0);
        write_cfg(CFG_CAPACITY, CFG_DATA_W'($urandom_range(TBL_DEPTH + 1, 2047)));
        run_random(40, 100);

        r.func    = FUNC_LSEARCH;
        r.key     = $urandom;
        probe_rsp = table_apply(r);
        while (probe_rsp.found) begin
            r.key     = $urandom;
            probe_rsp = table_apply(r);
        end
        send_req(r, 1'b0, RSP_OK);                      // miss: probes every stored entry
        r.func = FUNC_BSEARCH;
        send_req(r, 1'b0, RSP_OK);
        r.func = FUNC_LSEARCH;
        r.key  = tbl_keys[tbl_count - 1];
        send_req(r, 1'b0, RSP_OK);                      // hit on the top entry's key
        r.func = FUNC_BSEARCH;
        r.key  = tbl_keys[$urandom_range(0, tbl_count - 1)];
        send_req(r, 1'b0, RSP_OK);

        // Drain, then watch the tail window for stray responses.
        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
